// ===== sv/assert_macros.svh =====
// assertion macros shared by the disc id block
// no dependencies; the bodies are empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked on every rising edge outside reset
`define CDID_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen on a rising edge outside reset
`define CDID_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define CDID_ASSERT(label, clk, rst_n, prop, msg)
`define CDID_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== sv/cdid_pkg.sv =====
// types, widths and constants of the disc id block
// no dependencies; used by the front, back and top level files
package cdid_pkg;

    // sector arithmetic
    localparam int SECTORS_PER_SECOND = 75;
    localparam int OFFSET_SECTORS     = 2 * SECTORS_PER_SECOND;

    // field widths
    localparam int START_W   = 19;
    localparam int LENGTH_W  = 19;
    localparam int ID_W      = 32;
    localparam int TOTAL_W   = 14;
    localparam int SECS_W    = 13;
    localparam int PLAY_W    = 16;
    localparam int COUNT_W   = 8;
    localparam int DSUM_W    = 6;
    localparam int ID_SUM_W  = 8;

    // offset start and offset end sectors
    localparam int X_START_W = START_W + 1;
    localparam int X_END_W   = START_W + 2;

    // reciprocal of sectors per second, exact for any end sector value
    localparam int SEC_SHIFT = X_END_W + $clog2(SECTORS_PER_SECOND);
    localparam int unsigned SEC_RECIP =
        ((1 << SEC_SHIFT) + SECTORS_PER_SECOND - 1) / SECTORS_PER_SECOND;
    localparam int SEC_RECIP_W = $clog2(SEC_RECIP + 1);

    // reciprocal of one hundred, exact for any seconds value
    localparam int HUNDRED      = 100;
    localparam int HQ_W         = 7;
    localparam int HUND_SHIFT   = SECS_W + HQ_W;
    localparam int unsigned HUND_RECIP = ((1 << HUND_SHIFT) + HUNDRED - 1) / HUNDRED;
    localparam int HUND_RECIP_W = $clog2(HUND_RECIP + 1);

    // id byte modulus and track count ceiling
    localparam int ID_MOD    = 255;
    localparam int TRACK_MAX = 255;

    // digit sum of a two digit value
    localparam int TAB_DEPTH = 2 ** HQ_W;
    localparam int TAB_W     = 5;
    typedef logic [TAB_W-1:0] t_dsum_tab [TAB_DEPTH];

    function automatic t_dsum_tab build_dsum_tab();
        t_dsum_tab tab;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            tab[i] = TAB_W'(i / 10 + i % 10);
        end
        return tab;
    endfunction

    localparam t_dsum_tab DSUM_TAB = build_dsum_tab();

    // one track after the division, as it waits for the back part
    typedef struct packed {
        logic [SECS_W-1:0]  secs;
        logic [TOTAL_W-1:0] end_secs;
        logic               last;
    } t_mid_item;

    // one result item
    typedef struct packed {
        logic [ID_W-1:0]    disc_id;
        logic [TOTAL_W-1:0] total_seconds;
    } t_result;

endpackage

// ===== sv/cdid_fifo.sv =====
// small register queue with a count, used between the block's parts
// no dependencies; the user must not push when the count equals the depth, the queue does not enforce it
module cdid_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic [CNT_W-1:0] o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    // pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

// ===== sv/cdid_front.sv =====
// front part: takes track items, adds the offset and divides to seconds
// depends on cdid_pkg; feeds the middle queue through a two stage pipeline
module cdid_front #(
    parameter int QUEUE_DEPTH = 4,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [18:0]              i_track_start,
    input  logic [18:0]              i_track_length,
    input  logic                     i_is_last,
    input  logic [CNT_W-1:0]         i_mid_count,
    output logic                     o_full,
    output logic                     o_mid_push,
    output cdid_pkg::t_mid_item      o_mid_item
);

    import cdid_pkg::*;

    localparam int OCC_W    = CNT_W + 1;
    localparam int PS_W     = X_START_W + SEC_RECIP_W;
    localparam int PE_W     = X_END_W + SEC_RECIP_W;

    logic                 w_accept;
    logic [OCC_W-1:0]     w_occupancy;
    logic                 r_v1;
    logic                 r_v2;
    logic [X_START_W-1:0] n_x_start;
    logic [X_END_W-1:0]   n_x_end;
    logic [X_START_W-1:0] r_x_start;
    logic [X_END_W-1:0]   r_x_end;
    logic                 r_last1;
    logic [PS_W-1:0]      w_prod_start;
    logic [PE_W-1:0]      w_prod_end;
    logic [SECS_W-1:0]    r_secs;
    logic [TOTAL_W-1:0]   r_end_secs;
    logic                 r_last2;

    // room check counts items still in the pipeline
    assign w_occupancy = OCC_W'(i_mid_count) + OCC_W'(r_v1) + OCC_W'(r_v2);
    assign o_full      = (w_occupancy >= OCC_W'(QUEUE_DEPTH));
    assign w_accept    = i_push && !o_full;

    // two second offset on start and on end
    assign n_x_start = X_START_W'(i_track_start) + X_START_W'(OFFSET_SECTORS);
    assign n_x_end   = X_END_W'(i_track_start) + X_END_W'(i_track_length)
                     + X_END_W'(OFFSET_SECTORS);

    // divide by sectors per second through the reciprocal
    assign w_prod_start = PS_W'(r_x_start) * PS_W'(SEC_RECIP);
    assign w_prod_end   = PE_W'(r_x_end) * PE_W'(SEC_RECIP);

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        r_x_start  <= n_x_start;
        r_x_end    <= n_x_end;
        r_last1    <= i_is_last;
        r_secs     <= w_prod_start[SEC_SHIFT +: SECS_W];
        r_end_secs <= w_prod_end[SEC_SHIFT +: TOTAL_W];
        r_last2    <= r_last1;
    end

    assign o_mid_push          = r_v2;
    assign o_mid_item.secs     = r_secs;
    assign o_mid_item.end_secs = r_end_secs;
    assign o_mid_item.last     = r_last2;

endmodule

// ===== sv/cdid_back.sv =====
// back part: digit sum of the seconds, accumulation and result building
// depends on cdid_pkg; pops the middle queue and pushes the result queue
module cdid_back #(
    parameter int OUT_DEPTH = 4,
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_mid_empty,
    input  cdid_pkg::t_mid_item    i_mid_item,
    input  logic [OUT_CNT_W-1:0]   i_out_count,
    output logic                   o_mid_pop,
    output logic                   o_out_push,
    output cdid_pkg::t_result      o_result
);

    import cdid_pkg::*;

    localparam int OCC_W  = OUT_CNT_W + 1;
    localparam int PH_W   = SECS_W + HUND_RECIP_W;
    localparam int RAW_W  = ID_SUM_W + 1;

    logic [OCC_W-1:0]    w_occupancy;
    logic [PH_W-1:0]     w_prod_hund;
    logic                r1_valid;
    logic [SECS_W-1:0]   r1_secs;
    logic [TOTAL_W-1:0]  r1_end;
    logic                r1_last;
    logic [HQ_W-1:0]     r1_q100;
    logic [SECS_W-1:0]   w_hund_part;
    logic [SECS_W-1:0]   w_rem;
    logic [DSUM_W-1:0]   n2_dsum;
    logic                r2_valid;
    logic [SECS_W-1:0]   r2_secs;
    logic [TOTAL_W-1:0]  r2_end;
    logic                r2_last;
    logic [DSUM_W-1:0]   r2_dsum;
    logic [ID_SUM_W-1:0] r_digit_sum;
    logic [SECS_W-1:0]   r_first;
    logic [COUNT_W-1:0]  r_tracks;
    logic [RAW_W-1:0]    w_sum_raw;
    logic [ID_SUM_W-1:0] w_sum;
    logic [SECS_W-1:0]   w_first;
    logic [COUNT_W-1:0]  w_count;
    logic [PLAY_W-1:0]   w_play;

    // pop only when the result queue has room for everything in flight
    assign w_occupancy = OCC_W'(i_out_count) + OCC_W'(r1_valid) + OCC_W'(r2_valid);
    assign o_mid_pop   = !i_mid_empty && (w_occupancy < OCC_W'(OUT_DEPTH));

    // seconds divided by one hundred
    assign w_prod_hund = PH_W'(i_mid_item.secs) * PH_W'(HUND_RECIP);

    // remainder by one hundred, then two table lookups
    assign w_hund_part = SECS_W'(r1_q100) * SECS_W'(HUNDRED);
    assign w_rem       = r1_secs - w_hund_part;
    assign n2_dsum     = DSUM_W'(DSUM_TAB[r1_q100]) + DSUM_W'(DSUM_TAB[w_rem[HQ_W-1:0]]);

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r1_valid <= o_mid_pop;
            r2_valid <= r1_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        r1_secs <= i_mid_item.secs;
        r1_end  <= i_mid_item.end_secs;
        r1_last <= i_mid_item.last;
        r1_q100 <= w_prod_hund[HUND_SHIFT +: HQ_W];
        r2_secs <= r1_secs;
        r2_end  <= r1_end;
        r2_last <= r1_last;
        r2_dsum <= n2_dsum;
    end

    // running digit sum mod 255, first track seconds, saturating count
    assign w_sum_raw = RAW_W'(r_digit_sum) + RAW_W'(r2_dsum);
    assign w_sum     = (w_sum_raw >= RAW_W'(ID_MOD)) ? ID_SUM_W'(w_sum_raw - RAW_W'(ID_MOD))
                                                     : ID_SUM_W'(w_sum_raw);
    assign w_first   = (r_tracks == '0) ? r2_secs : r_first;
    assign w_count   = (r_tracks == COUNT_W'(TRACK_MAX)) ? r_tracks : r_tracks + 1'b1;
    assign w_play    = PLAY_W'(r2_end) - PLAY_W'(w_first);

    // disc state, cleared after each result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_sum <= '0;
            r_first     <= '0;
            r_tracks    <= '0;
        end else if (r2_valid) begin
            if (r2_last) begin
                r_digit_sum <= '0;
                r_first     <= '0;
                r_tracks    <= '0;
            end else begin
                r_digit_sum <= w_sum;
                r_first     <= w_first;
                r_tracks    <= w_count;
            end
        end
    end

    assign o_out_push             = r2_valid && r2_last;
    assign o_result.disc_id       = {w_sum, w_play, w_count};
    assign o_result.total_seconds = r2_end;

endmodule

// ===== sv/cddb_disc_id.sv =====
// top level of the disc id block: front, middle queue, back, result queue
// depends on cdid_pkg, cdid_fifo, cdid_front, cdid_back and assert_macros.svh
//
//  port group   direction  handshake           payload
//  track in     input      push / full         i_track_start, i_track_length, i_is_last
//  result out   output     empty / pop         o_disc_id, o_total_seconds
//
// one track item can be taken every cycle while full is low; once its last track
// is taken, a result item passes the two divider stages, the middle queue and the
// two digit sum stages, then the result queue, before it shows on the output
// full rises when the middle queue and the divider stages hold MID_DEPTH items
// a stalled result side fills the result queue, then the middle queue, then full
// synchronous active low reset empties both queues and clears the disc state
`include "assert_macros.svh"

module cddb_disc_id #(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [18:0] i_track_start,
    input  logic [18:0] i_track_length,
    input  logic        i_is_last,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_disc_id,
    output logic [13:0] o_total_seconds
);

    import cdid_pkg::*;

    localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
    localparam int MID_W     = $bits(t_mid_item);
    localparam int OUT_W     = $bits(t_result);

    logic                 w_mid_push;
    t_mid_item            w_mid_in;
    logic [MID_W-1:0]     w_mid_out_bits;
    t_mid_item            w_mid_out;
    logic                 w_mid_empty;
    logic [MID_CNT_W-1:0] w_mid_count;
    logic                 w_mid_pop;
    logic                 w_out_push;
    t_result              w_out_in;
    logic [OUT_W-1:0]     w_out_bits;
    t_result              w_out_item;
    logic [OUT_CNT_W-1:0] w_out_count;

    // front part
    cdid_front #(
        .QUEUE_DEPTH (MID_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_track_start  (i_track_start),
        .i_track_length (i_track_length),
        .i_is_last      (i_is_last),
        .i_mid_count    (w_mid_count),
        .o_full         (full),
        .o_mid_push     (w_mid_push),
        .o_mid_item     (w_mid_in)
    );

    // queue between front and back
    cdid_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_mid_in),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_out_bits),
        .o_empty (w_mid_empty),
        .o_count (w_mid_count)
    );

    assign w_mid_out = t_mid_item'(w_mid_out_bits);

    // back part
    cdid_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (w_mid_empty),
        .i_mid_item  (w_mid_out),
        .i_out_count (w_out_count),
        .o_mid_pop   (w_mid_pop),
        .o_out_push  (w_out_push),
        .o_result    (w_out_in)
    );

    // result queue
    cdid_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_in),
        .i_pop   (pop && !empty),
        .o_data  (w_out_bits),
        .o_empty (empty),
        .o_count (w_out_count)
    );

    assign w_out_item      = t_result'(w_out_bits);
    assign o_disc_id       = w_out_item.disc_id;
    assign o_total_seconds = w_out_item.total_seconds;

    // queue room and pop checks
    `CDID_ASSERT(a_mid_room, i_clk, i_rst_n, w_mid_push |-> (w_mid_count < MID_CNT_W'(MID_DEPTH)), "middle queue written while full")
    `CDID_ASSERT(a_out_room, i_clk, i_rst_n, w_out_push |-> (w_out_count < OUT_CNT_W'(OUT_DEPTH)), "result queue written while full")
    `CDID_NEVER(a_mid_pop_empty, i_clk, i_rst_n, w_mid_pop && w_mid_empty, "middle queue popped while empty")

endmodule

// ===== verif/cddb_disc_id_tb.sv =====
// self-checking testbench for the cddb disc id block
// depends on cdid_pkg and the cddb_disc_id top level; holds its own disc id scoreboard
module cddb_disc_id_tb;
    import cdid_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 20;

    // running disc state and the disc ids still owed by the block
    class disc_id_tracker;
        t_result             owed_ids[$];
        logic [12:0]         dsum_acc;
        logic [TOTAL_W-1:0]  first_secs;
        logic [COUNT_W-1:0]  track_cnt;
        int                  errors;

        function new();
            errors = 0;
            clear_disc();
        endfunction

        function void clear_disc();
            dsum_acc   = '0;
            first_secs = '0;
            track_cnt  = '0;
        endfunction

        function int digit_sum(int v);
            int s;
            s = 0;
            while (v > 0) begin
                s += v % 10;
                v /= 10;
            end
            return s;
        endfunction

        function int pending();
            return owed_ids.size();
        endfunction

        // one accepted track item
        function void take_track(logic [START_W-1:0] start, logic [LENGTH_W-1:0] len,
                                 logic last);
            int secs;
            int dsum;
            int first;
            int cnt;
            int end_secs;
            logic [PLAY_W-1:0] play;
            t_result want;
            secs  = (int'(start) + OFFSET_SECTORS) / SECTORS_PER_SECOND;
            dsum  = (int'(dsum_acc) + digit_sum(secs)) % ID_MOD;
            first = (track_cnt == 0) ? secs : int'(first_secs);
            cnt   = (track_cnt < TRACK_MAX) ? int'(track_cnt) + 1 : TRACK_MAX;
            if (!last) begin
                dsum_acc   = 13'(dsum);
                first_secs = TOTAL_W'(first);
                track_cnt  = COUNT_W'(cnt);
            end else begin
                // playing seconds wrap when starts are not ascending
                end_secs = (int'(start) + int'(len) + OFFSET_SECTORS) / SECTORS_PER_SECOND;
                play = PLAY_W'(end_secs - first);
                want.disc_id       = {8'(dsum), play, 8'(cnt)};
                want.total_seconds = TOTAL_W'(end_secs);
                owed_ids.insert(owed_ids.size(), want);
                clear_disc();
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        // one accepted result item against the oldest owed disc id
        task check_result(logic [ID_W-1:0] id, logic [TOTAL_W-1:0] total);
            t_result want;
            if (owed_ids.size() == 0) begin
                report_mismatch($sformatf("unexpected result id %h total %0d", id, total));
            end else begin
                want = owed_ids.pop_front();
                if (id !== want.disc_id)
                    report_mismatch($sformatf("disc id %h, want %h", id, want.disc_id));
                if (total !== want.total_seconds)
                    report_mismatch($sformatf("total seconds %0d, want %0d",
                                              total, want.total_seconds));
            end
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                push;
    logic                full;
    logic [START_W-1:0]  i_track_start;
    logic [LENGTH_W-1:0] i_track_length;
    logic                i_is_last;
    logic                empty;
    logic                pop;
    logic [ID_W-1:0]     o_disc_id;
    logic [TOTAL_W-1:0]  o_total_seconds;

    disc_id_tracker tracker = new();
    int  items_sent;
    bit  hold_req;
    bit  holding;

    cddb_disc_id dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_track_start   (i_track_start),
        .i_track_length  (i_track_length),
        .i_is_last       (i_is_last),
        .empty           (empty),
        .pop             (pop),
        .o_disc_id       (o_disc_id),
        .o_total_seconds (o_total_seconds)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #3000000;
        $display("status: fail");
        $finish;
    end

    // handshake monitor, samples values from before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full)
                tracker.take_track(i_track_start, i_track_length, i_is_last);
            if (pop && !empty)
                tracker.check_result(o_disc_id, o_total_seconds);
        end
    end

    // gap after an item: mostly none or short, a few long
    function automatic int item_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one track item and hold it until accepted
    task automatic send_track(logic [START_W-1:0] start, logic [LENGTH_W-1:0] len,
                              logic last, int gap);
        push           <= 1'b1;
        i_track_start  <= start;
        i_track_length <= len;
        i_is_last      <= last;
        do @(posedge i_clk); while (full);
        items_sent++;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // one disc of random content, ascending starts or noise starts
    task automatic send_disc(int n_tracks, bit ascending, bit burst);
        logic [START_W-1:0]  pos;
        logic [START_W-1:0]  start;
        logic [LENGTH_W-1:0] len;
        pos = ascending ? START_W'($urandom_range(0, 20000)) : START_W'($urandom);
        for (int i = 0; i < n_tracks; i++) begin
            start = ascending ? pos : START_W'($urandom);
            len = $urandom_range(0, 1) ? LENGTH_W'($urandom)
                                       : LENGTH_W'($urandom_range(0, 60000));
            send_track(start, len, i == n_tracks - 1, burst ? 0 : item_gap());
            pos = pos + START_W'($urandom_range(0, n_tracks > 40 ? 1500 : 40000));
        end
    endtask

    // wait until every owed disc id has come out
    task automatic wait_drained();
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // result side: random pop runs and gaps, one long hold on request
    initial begin
        pop <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                pop     <= 1'b0;
                holding  = 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                holding  = 1'b0;
                hold_req = 1'b0;
            end else if ($urandom_range(0, 3) != 0) begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end else begin
                pop <= 1'b0;
                if ($urandom_range(0, 99) < 85)
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                else
                    repeat ($urandom_range(15, 50)) @(posedge i_clk);
            end
        end
    end

    // stimulus and end of run
    initial begin
        int n;
        int r;
        items_sent      = 0;
        hold_req        = 1'b0;
        holding         = 1'b0;
        i_rst_n        <= 1'b0;
        push           <= 1'b0;
        i_track_start  <= '0;
        i_track_length <= '0;
        i_is_last      <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single track discs at the field extremes
        send_track('0, '0, 1'b1, item_gap());
        send_track('1, '1, 1'b1, item_gap());
        // short ascending disc, lengths of inner tracks ignored
        send_track(19'd0,     '1,        1'b0, item_gap());
        send_track(19'd13500, '1,        1'b0, item_gap());
        send_track(19'd33000, '0,        1'b0, item_gap());
        send_track(19'd52000, 19'd25000, 1'b1, item_gap());
        // descending starts, playing seconds wrap
        send_track(19'd500000, 19'd0, 1'b0, item_gap());
        send_track(19'd0,      19'd0, 1'b1, item_gap());
        // digit sum crosses the id byte modulus, 8 tracks of 32
        for (int i = 0; i < 7; i++)
            send_track(19'd524025, LENGTH_W'($urandom), 1'b0, item_gap());
        send_track(19'd524025, 19'd1000, 1'b1, item_gap());
        push <= 1'b0;
        wait_drained();

        // result side holds off while short discs keep coming
        hold_req = 1'b1;
        while (!holding) @(posedge i_clk);
        for (int i = 0; i < 30; i++)
            send_disc($urandom_range(1, 2), 1'b1, 1'b1);
        push <= 1'b0;
        wait_drained();

        // track count saturation, exactly at the ceiling and past it
        items_sent = 0;
        send_disc(TRACK_MAX, 1'b1, 1'b0);
        send_disc($urandom_range(TRACK_MAX + 1, 300), 1'b1, 1'b1);

        // random discs, mostly ascending, some noise starts
        while (items_sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                n = $urandom_range(1, 8);
            else if (r < 90)
                n = $urandom_range(9, 30);
            else
                n = 1;
            send_disc(n, $urandom_range(0, 9) != 0, $urandom_range(0, 7) == 0);
            if ($urandom_range(0, 99) == 0) begin
                push <= 1'b0;
                wait_drained();
            end
        end
        push <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/cdid_pkg.sv
sv/cdid_fifo.sv
sv/cdid_front.sv
sv/cdid_back.sv
sv/cddb_disc_id.sv
verif/cddb_disc_id_tb.sv
